@@ src/simon_pkg.sv @@
// Shared types, constants and word-rotation helpers for the Simon cipher block.
`default_nettype none

package simon_pkg;

    localparam int WORD_W          = 64;
    localparam int MAX_ROUNDS_DEF  = 72;
    localparam int Z_LEN           = 62;

    // Word size codes
    localparam logic [2:0] WS_16 = 3'd0;
    localparam logic [2:0] WS_24 = 3'd1;
    localparam logic [2:0] WS_32 = 3'd2;
    localparam logic [2:0] WS_48 = 3'd3;
    localparam logic [2:0] WS_64 = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_WORD_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_WORDS = 3'd1;
    localparam logic [2:0] REG_ROUNDS    = 3'd2;
    localparam logic [2:0] REG_Z_SELECT  = 3'd3;
    localparam logic [2:0] REG_KEY_0     = 3'd4;
    localparam logic [2:0] REG_KEY_1     = 3'd5;
    localparam logic [2:0] REG_KEY_2     = 3'd6;
    localparam logic [2:0] REG_KEY_3     = 3'd7;

    // Bit 61 holds element 0 of each sequence
    localparam logic [Z_LEN-1:0] Z_SEQ [5] = '{
        62'h3E8958737D12B0E6,
        62'h23BE4C2D477C985A,
        62'h2BDC0D262847E5B3,
        62'h36EB19781229CD0F,
        62'h3479AD88170CA4EF
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FETCH,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef logic [WORD_W-1:0] t_word;

    function automatic t_word code_mask(input logic [2:0] code);
        t_word m;
        unique case (code)
            WS_16:   m = 64'h0000_0000_0000_FFFF;
            WS_24:   m = 64'h0000_0000_00FF_FFFF;
            WS_32:   m = 64'h0000_0000_FFFF_FFFF;
            WS_48:   m = 64'h0000_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // x is already masked; d is a constant at every call site
    function automatic t_word rot_left(input t_word x, input logic [2:0] code,
                                       input int unsigned d);
        t_word y;
        unique case (code)
            WS_16:   y = (x << d) | (x >> (16 - d));
            WS_24:   y = (x << d) | (x >> (24 - d));
            WS_32:   y = (x << d) | (x >> (32 - d));
            WS_48:   y = (x << d) | (x >> (48 - d));
            default: y = (x << d) | (x >> (64 - d));
        endcase
        return y & code_mask(code);
    endfunction

    function automatic t_word rot_right(input t_word x, input logic [2:0] code,
                                        input int unsigned d);
        t_word y;
        unique case (code)
            WS_16:   y = (x >> d) | (x << (16 - d));
            WS_24:   y = (x >> d) | (x << (24 - d));
            WS_32:   y = (x >> d) | (x << (32 - d));
            WS_48:   y = (x >> d) | (x << (48 - d));
            default: y = (x >> d) | (x << (64 - d));
        endcase
        return y & code_mask(code);
    endfunction

    function automatic t_word round_f(input t_word x, input logic [2:0] code);
        return (rot_left(x, code, 1) & rot_left(x, code, 8)) ^ rot_left(x, code, 2);
    endfunction

endpackage

`default_nettype wire

@@ src/simon_block_cipher.sv @@
// Simon cipher with the round keys held in a RAM; zero rounds pass the halves through.
// Each item passes through the fetch, round and done states, going straight to done with
//   zero rounds; after a configuration change, the round keys are re-expanded first.
// One item at a time: a new input is taken only in idle, after the last result is loaded;
//   each round does one Feistel round and one round-key read per cycle from the round-key RAM.
// Reset: synchronous, active low; configuration registers return to defaults and keys are re-expanded.
`default_nettype none

module simon_block_cipher
    import simon_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // APB configuration port
    input  wire logic         i_psel,
    input  wire logic         i_penable,
    input  wire logic         i_pwrite,
    input  wire logic [5:0]   i_paddr,
    input  wire logic [63:0]  i_pwdata,
    output logic      [63:0]  o_prdata,
    output logic              o_pready,
    // input stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,  // [63:0] left_in, [127:64] right_in
    input  wire logic         i_s_tuser,  // [0] req_type (1 = decrypt)
    // result stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic      [127:0] o_m_tdata   // [63:0] left_out, [127:64] right_out
);

    localparam int AW = $clog2(MAX_ROUNDS);
    localparam int CW = $clog2(MAX_ROUNDS + 1);

    // configuration registers
    logic [2:0]  r_wsc;
    logic [2:0]  r_kw;
    logic [6:0]  r_rc;
    logic [2:0]  r_zs;
    t_word       r_key [4];
    logic        r_dirty;

    // control and datapath
    t_state      r_state, n_state;
    logic        r_dec;
    t_word       r_left, r_right;
    t_word       r_out_left, r_out_right;
    logic        r_out_valid;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_kidx;
    logic [5:0]  r_zidx;
    t_word       r_hist [4];
    t_word       r_rdata;
    t_word       mem [MAX_ROUNDS];

    // decoded configuration
    logic [2:0]    code;
    logic [2:0]    m_eff;
    logic [2:0]    zs_eff;
    logic [CW-1:0] rounds;
    t_word         mask;
    t_word         cst;

    logic          cfg_wr;
    logic          in_xfer;
    logic          wr_en, rd_en, load_out, last_key, last_round;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] rd_idx;
    t_word         new_key, t_a, t_b, k_im, sched_key;
    logic          zbit;

    assign code   = (r_wsc > WS_64) ? WS_64 : r_wsc;
    assign m_eff  = (r_kw < 3'd2) ? 3'd2 : ((r_kw > 3'd4) ? 3'd4 : r_kw);
    assign zs_eff = (r_zs > 3'd4) ? 3'd4 : r_zs;
    assign rounds = (32'(r_rc) > MAX_ROUNDS) ? CW'(MAX_ROUNDS) : CW'(r_rc);
    assign mask   = code_mask(code);
    assign cst    = mask & ~t_word'(3);

    // ---------------- configuration port ----------------
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsc   <= WS_64;
            r_kw    <= 3'd4;
            r_rc    <= 7'd72;
            r_zs    <= 3'd4;
            r_key   <= '{default: '0};
            r_dirty <= 1'b1;
        end else begin
            if (cfg_wr) begin
                r_dirty <= 1'b1;
                unique case (i_paddr[5:3])
                    REG_WORD_SIZE: r_wsc    <= i_pwdata[2:0];
                    REG_KEY_WORDS: r_kw     <= i_pwdata[2:0];
                    REG_ROUNDS:    r_rc     <= i_pwdata[6:0];
                    REG_Z_SELECT:  r_zs     <= i_pwdata[2:0];
                    REG_KEY_0:     r_key[0] <= i_pwdata;
                    REG_KEY_1:     r_key[1] <= i_pwdata;
                    REG_KEY_2:     r_key[2] <= i_pwdata;
                    REG_KEY_3:     r_key[3] <= i_pwdata;
                    default:       r_key[3] <= i_pwdata;
                endcase
            end else if (r_state == ST_EXPAND && last_key) begin
                r_dirty <= 1'b0;
            end
        end
    end

    always_comb begin
        unique case (i_paddr[5:3])
            REG_WORD_SIZE: o_prdata = 64'(r_wsc);
            REG_KEY_WORDS: o_prdata = 64'(r_kw);
            REG_ROUNDS:    o_prdata = 64'(r_rc);
            REG_Z_SELECT:  o_prdata = 64'(r_zs);
            REG_KEY_0:     o_prdata = r_key[0];
            REG_KEY_1:     o_prdata = r_key[1];
            REG_KEY_2:     o_prdata = r_key[2];
            REG_KEY_3:     o_prdata = r_key[3];
            default:       o_prdata = '0;
        endcase
    end

    // ---------------- key schedule step ----------------
    // r_hist[0] holds k[i-1], r_hist[1] k[i-2] and so on
    always_comb begin
        t_a = rot_right(r_hist[0], code, 3);
        if (m_eff == 3'd4) begin
            t_a = t_a ^ r_hist[2];
        end
        t_b = t_a ^ rot_right(t_a, code, 1);
        unique case (m_eff)
            3'd2:    k_im = r_hist[1];
            3'd3:    k_im = r_hist[2];
            default: k_im = r_hist[3];
        endcase
        zbit      = Z_SEQ[zs_eff][6'd61 - r_zidx];
        sched_key = (k_im ^ t_word'(zbit) ^ t_b ^ cst) & mask;
        new_key   = (r_kidx < CW'(m_eff)) ? (r_key[r_kidx[1:0]] & mask) : sched_key;
    end

    assign last_key   = (r_kidx == rounds - CW'(1));
    assign last_round = (r_cnt == rounds - CW'(1));

    // ---------------- control ----------------
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        rd_idx   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (rounds == '0) begin
                        n_state = ST_DONE;
                    end else if (r_dirty) begin
                        n_state = ST_EXPAND;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_EXPAND: begin
                wr_en = 1'b1;
                if (last_key) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                rd_en   = 1'b1;
                rd_idx  = r_dec ? (rounds - CW'(1)) : '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                rd_en  = !last_round;
                rd_idx = r_dec ? (rounds - CW'(2) - r_cnt) : (r_cnt + CW'(1));
                if (last_round) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign rd_addr = rd_idx[AW-1:0];

    // ---------------- round-key RAM ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_kidx[AW-1:0]] <= new_key;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dec   <= i_s_tuser;
            r_left  <= i_s_tdata[63:0] & mask;
            r_right <= i_s_tdata[127:64] & mask;
            r_kidx  <= '0;
            r_zidx  <= '0;
            r_cnt   <= '0;
        end
        if (r_state == ST_EXPAND) begin
            r_kidx  <= r_kidx + CW'(1);
            r_hist[0] <= new_key;
            r_hist[1] <= r_hist[0];
            r_hist[2] <= r_hist[1];
            r_hist[3] <= r_hist[2];
            if (!(r_kidx < CW'(m_eff))) begin
                r_zidx <= (r_zidx == 6'(Z_LEN - 1)) ? '0 : r_zidx + 6'd1;
            end
        end
        if (r_state == ST_ROUND) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_dec) begin
                r_right <= r_left ^ round_f(r_right, code) ^ r_rdata;
                r_left  <= r_right;
            end else begin
                r_left  <= r_right ^ round_f(r_left, code) ^ r_rdata;
                r_right <= r_left;
            end
        end
        if (load_out) begin
            r_out_left  <= r_left;
            r_out_right <= r_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_right, r_out_left};

    // ---------------- assertions ----------------
    a_last_round_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && last_round) |=> (r_state == ST_DONE))
        else $error("last round did not finish the item");

    a_expand_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPAND) |-> (r_kidx < rounds))
        else $error("key expansion ran past the round count");

    a_stale_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_dirty && rounds != '0) |=> (r_state == ST_EXPAND))
        else $error("item started with stale round keys");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(o_m_tdata)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ bench/simon_block_cipher_tb.sv @@
// Self-checking bench for the Simon cipher: APB setup, block stream, own round model.
`timescale 1ns / 100ps

module simon_block_cipher_tb
    import simon_pkg::*;
();

    localparam int ROUNDS_MAX = 72;
    localparam int RANDOM_BLOCKS = 500;
    localparam logic REQ_ENC = 1'b0;
    localparam logic REQ_DEC = 1'b1;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_A = 64'h1918_1110_0908_0100;
    localparam logic [63:0] KEY_B = 64'hA5C3_0F96_5A3C_F069;

    // element 0 of each sequence in bit 61
    localparam logic [61:0] Z_CONST [5] = '{
        62'h3E8958737D12B0E6,
        62'h23BE4C2D477C985A,
        62'h2BDC0D262847E5B3,
        62'h36EB19781229CD0F,
        62'h3479AD88170CA4EF
    };

    typedef struct packed {
        logic [63:0] lft;
        logic [63:0] rgt;
    } block_t;

    typedef struct packed {
        logic [2:0]  ws;
        logic [2:0]  kw;
        logic [6:0]  nr;
        logic [2:0]  zs;
        logic [63:0] key_fill;
        logic        req;
        logic [63:0] lft;
        logic [63:0] rgt;
        bit          has_exp;
        logic [63:0] exp_l;
        logic [63:0] exp_r;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // [63:0] left_in, [127:64] right_in
    logic         s_tuser = 1'b0; // [0] req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // [63:0] left_out, [127:64] right_out

    // register copy, reset values
    logic [2:0]  cfg_ws = WS_64;
    logic [2:0]  cfg_kw = 3'd4;
    logic [6:0]  cfg_nr = 7'd72;
    logic [2:0]  cfg_zs = 3'd4;
    logic [63:0] cfg_key [4] = '{64'd0, 64'd0, 64'd0, 64'd0};

    block_t pending_blocks [$];
    int     fail_count = 0;
    int     stall_left = 0;
    bit     calm = 1'b0;

    simon_block_cipher uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] width_mask(input int unsigned w);
        return (w >= 64) ? ALL_ONES : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [63:0] rol(input logic [63:0] x, input int unsigned d,
                                       input int unsigned w);
        return ((x << d) | (x >> (w - d))) & width_mask(w);
    endfunction

    function automatic logic [63:0] ror(input logic [63:0] x, input int unsigned d,
                                       input int unsigned w);
        return ((x >> d) | (x << (w - d))) & width_mask(w);
    endfunction

    // expands the schedule from the register copy and runs the rounds
    function automatic block_t cipher_predict(input logic req, input logic [63:0] lin,
                                              input logic [63:0] rin);
        int unsigned w, m, nr, zs, k, i;
        logic [63:0] mask, c, t, l, r, f;
        logic [63:0] rk [ROUNDS_MAX];
        block_t res;
        case (cfg_ws)
            WS_16:   w = 16;
            WS_24:   w = 24;
            WS_32:   w = 32;
            WS_48:   w = 48;
            default: w = 64;
        endcase
        mask = width_mask(w);
        c = mask & ~64'd3;
        m = (cfg_kw < 3'd2) ? 2 : (cfg_kw > 3'd4) ? 4 : cfg_kw;
        nr = (cfg_nr > ROUNDS_MAX) ? ROUNDS_MAX : cfg_nr;
        zs = (cfg_zs > 3'd4) ? 4 : cfg_zs;
        for (i = 0; i < nr; i++) begin
            if (i < m) begin
                rk[i] = cfg_key[i] & mask;
            end else begin
                k = (i - m) % 62;
                t = ror(rk[i-1], 3, w);
                if (m == 4)
                    t = t ^ rk[i-3];
                t = t ^ ror(t, 1, w);
                rk[i] = (rk[i-m] ^ {63'd0, Z_CONST[zs][61-k]} ^ t ^ c) & mask;
            end
        end
        l = lin & mask;
        r = rin & mask;
        for (i = 0; i < nr; i++) begin
            if (req == REQ_ENC) begin
                f = (rol(l, 1, w) & rol(l, 8, w)) ^ rol(l, 2, w);
                t = l;
                l = (r ^ f ^ rk[i]) & mask;
                r = t;
            end else begin
                f = (rol(r, 1, w) & rol(r, 8, w)) ^ rol(r, 2, w);
                t = r;
                r = (l ^ f ^ rk[nr-1-i]) & mask;
                l = t;
            end
        end
        res.lft = l;
        res.rgt = r;
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 80);
    endfunction

    function automatic logic [63:0] pick_word();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8)
            return ALL_ONES;
        else if (p < 14)
            return 64'd0;
        else
            return {$urandom, $urandom};
    endfunction

    // result side: check, then choose next tready
    always @(posedge clk) begin : result_check
        int p;
        block_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_blocks.size() == 0) begin
                $error("result with nothing pending: left_out %h right_out %h",
                       m_tdata[63:0], m_tdata[127:64]);
                fail_count++;
            end else begin
                want = pending_blocks.pop_front();
                if (m_tdata[63:0] !== want.lft) begin
                    $error("left_out: expected %h, got %h", want.lft, m_tdata[63:0]);
                    fail_count++;
                end
                if (m_tdata[127:64] !== want.rgt) begin
                    $error("right_out: expected %h, got %h", want.rgt, m_tdata[127:64]);
                    fail_count++;
                end
            end
        end
        p = $urandom_range(0, 99);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (calm || p >= 30) begin
            m_tready <= 1'b1;
        end else begin
            stall_left = (p < 4) ? $urandom_range(20, 120) : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
    end

    // all tasks are entered and left on a rising edge
    task automatic send_block(input logic req, input logic [63:0] lft, input logic [63:0] rgt,
                              input bit has_exp, input logic [63:0] exp_l,
                              input logic [63:0] exp_r);
        int gap;
        block_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rgt, lft};
        s_tuser <= req;
        do @(posedge clk); while (!s_tready);
        if (has_exp) begin
            want.lft = exp_l;
            want.rgt = exp_r;
        end else begin
            want = cipher_predict(req, lft, rgt);
        end
        pending_blocks.push_back(want);
    endtask

    task automatic drain_blocks();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WORD_SIZE: cfg_ws = value[2:0];
            REG_KEY_WORDS: cfg_kw = value[2:0];
            REG_ROUNDS:    cfg_nr = value[6:0];
            REG_Z_SELECT:  cfg_zs = value[2:0];
            REG_KEY_0:     cfg_key[0] = value;
            REG_KEY_1:     cfg_key[1] = value;
            REG_KEY_2:     cfg_key[2] = value;
            default:       cfg_key[3] = value;
        endcase
    endtask

    // writes only the registers that change, once the block has gone quiet
    task automatic apply_config(input logic [2:0] ws, input logic [2:0] kw,
                                input logic [6:0] nr, input logic [2:0] zs,
                                input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3);
        logic [63:0] want [8];
        logic [63:0] have [8];
        bit dirty;
        int i;
        want = '{64'(ws), 64'(kw), 64'(nr), 64'(zs), k0, k1, k2, k3};
        have = '{64'(cfg_ws), 64'(cfg_kw), 64'(cfg_nr), 64'(cfg_zs),
                 cfg_key[0], cfg_key[1], cfg_key[2], cfg_key[3]};
        dirty = 1'b0;
        for (i = 0; i < 8; i++)
            if (want[i] !== have[i])
                dirty = 1'b1;
        if (dirty) begin
            drain_blocks();
            for (i = 0; i < 8; i++)
                if (want[i] !== have[i])
                    reg_write(3'(i), want[i]);
        end
    endtask

    dir_row_t dir_rows [25] = '{
        // reset configuration
        '{WS_64, 3'd4, 7'd72, 3'd4, 64'd0, REQ_ENC, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0},
        '{WS_64, 3'd4, 7'd72, 3'd4, 64'd0, REQ_DEC, ALL_ONES, ALL_ONES, 1'b0, 64'd0, 64'd0},
        // each width and z sequence
        '{WS_16, 3'd4, 7'd32, 3'd0, KEY_A, REQ_ENC, 64'h6565, 64'h6877, 1'b0, 64'd0, 64'd0},
        '{WS_16, 3'd4, 7'd32, 3'd0, KEY_A, REQ_DEC, ALL_ONES, 64'd0, 1'b0, 64'd0, 64'd0},
        '{WS_24, 3'd3, 7'd36, 3'd1, KEY_A, REQ_ENC, 64'h0A_1B2C, ALL_ONES, 1'b0, 64'd0,
          64'd0},
        '{WS_32, 3'd3, 7'd42, 3'd2, KEY_B, REQ_DEC, 64'h1234_5678, 64'h9ABC_DEF0, 1'b0,
          64'd0, 64'd0},
        '{WS_32, 3'd4, 7'd44, 3'd3, KEY_B, REQ_ENC, 64'd0, ALL_ONES, 1'b0, 64'd0, 64'd0},
        '{WS_48, 3'd2, 7'd52, 3'd2, KEY_B, REQ_ENC, ALL_ONES, 64'h8000_0000_0000_0001,
          1'b0, 64'd0, 64'd0},
        '{WS_48, 3'd3, 7'd54, 3'd3, ALL_ONES, REQ_DEC, 64'h5555_5555_5555_5555,
          64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 64'd0},
        // long schedule, z index wraps
        '{WS_64, 3'd2, 7'd72, 3'd2, ALL_ONES, REQ_ENC, 64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210, 1'b0, 64'd0, 64'd0},
        '{WS_64, 3'd3, 7'd69, 3'd3, KEY_A, REQ_DEC, ALL_ONES, 64'd0, 1'b0, 64'd0, 64'd0},
        '{WS_64, 3'd4, 7'd72, 3'd4, ALL_ONES, REQ_ENC, ALL_ONES, ALL_ONES, 1'b0, 64'd0,
          64'd0},
        // zero rounds pass the masked halves through
        '{WS_24, 3'd4, 7'd0, 3'd1, KEY_A, REQ_ENC, ALL_ONES, ALL_ONES, 1'b1,
          64'hFF_FFFF, 64'hFF_FFFF},
        '{WS_64, 3'd4, 7'd0, 3'd1, KEY_A, REQ_DEC, 64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210},
        // fewer rounds than key words
        '{WS_16, 3'd4, 7'd1, 3'd0, KEY_B, REQ_ENC, 64'hFFFF, 64'h0001, 1'b0, 64'd0, 64'd0},
        '{WS_16, 3'd4, 7'd3, 3'd0, KEY_B, REQ_DEC, 64'h8000, 64'hFFFF, 1'b0, 64'd0, 64'd0},
        // round count saturates
        '{WS_16, 3'd2, 7'd127, 3'd0, KEY_B, REQ_ENC, ALL_ONES, 64'h1234, 1'b0, 64'd0,
          64'd0},
        '{WS_32, 3'd2, 7'd73, 3'd1, KEY_B, REQ_DEC, 64'hDEAD_BEEF, 64'h0BAD_F00D, 1'b0,
          64'd0, 64'd0},
        // out-of-range width code
        '{3'd7, 3'd4, 7'd72, 3'd4, KEY_A, REQ_ENC, 64'h0F0F_0F0F_0F0F_0F0F, ALL_ONES,
          1'b0, 64'd0, 64'd0},
        '{3'd5, 3'd3, 7'd40, 3'd2, KEY_A, REQ_DEC, ALL_ONES, 64'h0F0F_0F0F_0F0F_0F0F,
          1'b0, 64'd0, 64'd0},
        // out-of-range key word counts
        '{WS_32, 3'd0, 7'd40, 3'd2, KEY_A, REQ_ENC, 64'h1111_2222, 64'h3333_4444, 1'b0,
          64'd0, 64'd0},
        '{WS_32, 3'd1, 7'd40, 3'd2, KEY_A, REQ_DEC, 64'h1111_2222, 64'h3333_4444, 1'b0,
          64'd0, 64'd0},
        '{WS_32, 3'd7, 7'd40, 3'd2, KEY_A, REQ_ENC, 64'h1111_2222, 64'h3333_4444, 1'b0,
          64'd0, 64'd0},
        // out-of-range z select
        '{WS_48, 3'd4, 7'd48, 3'd7, KEY_B, REQ_ENC, 64'hCAFE_0000_BABE, ALL_ONES, 1'b0,
          64'd0, 64'd0},
        '{WS_48, 3'd4, 7'd48, 3'd5, KEY_B, REQ_DEC, ALL_ONES, 64'hCAFE_0000_BABE, 1'b0,
          64'd0, 64'd0}
    };

    initial begin : stimulus
        int n, i, p, per_phase, random_sent;
        logic [63:0] fill, keys [4];
        logic [2:0] ws, kw, zs;
        logic [6:0] nr;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < 25; n++) begin
            fill = dir_rows[n].key_fill;
            for (i = 0; i < 4; i++)
                keys[i] = (fill << (16 * i)) | (fill >> (64 - 16 * i));
            apply_config(dir_rows[n].ws, dir_rows[n].kw, dir_rows[n].nr, dir_rows[n].zs,
                         keys[0], keys[1], keys[2], keys[3]);
            send_block(dir_rows[n].req, dir_rows[n].lft, dir_rows[n].rgt,
                       dir_rows[n].has_exp, dir_rows[n].exp_l, dir_rows[n].exp_r);
        end

        random_sent = 0;
        while (random_sent < RANDOM_BLOCKS) begin
            p = $urandom_range(0, 99);
            ws = (p < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
            p = $urandom_range(0, 99);
            kw = (p < 85) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(0, 7));
            p = $urandom_range(0, 99);
            if (p < 6)
                nr = 7'd1;
            else if (p < 14)
                nr = 7'd72;
            else if (p < 18)
                nr = 7'd0;
            else if (p < 23)
                nr = 7'($urandom_range(73, 127));
            else
                nr = 7'($urandom_range(1, 72));
            p = $urandom_range(0, 99);
            zs = (p < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
            for (i = 0; i < 4; i++)
                keys[i] = pick_word();
            apply_config(ws, kw, nr, zs, keys[0], keys[1], keys[2], keys[3]);
            calm = ($urandom_range(0, 3) == 0);
            per_phase = $urandom_range(5, 30);
            for (i = 0; i < per_phase; i++)
                send_block(1'($urandom_range(0, 1)), pick_word(), pick_word(),
                           1'b0, 64'd0, 64'd0);
            random_sent += per_phase;
        end

        drain_blocks();
        repeat (ROUNDS_MAX + 8) @(posedge clk);
        if (fail_count == 0 && pending_blocks.size() == 0)
            $display("simon_block_cipher_tb passed");
        else
            $display("simon_block_cipher_tb failed");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("simon_block_cipher_tb failed");
        $finish;
    end

endmodule
